// ----- src/ecp_pkg.sv -----
// Shared types and constants for the expansion card identity and chunk directory parser.
`default_nettype none

package ecp_pkg;

    localparam int unsigned DATA_W     = 8;
    localparam int unsigned OUT_DATA_W = 176;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned ERR_W      = 3;
    localparam int unsigned POS_W      = 3;

    // Record kinds.
    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHUNK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd3;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NOT_CONF   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_RSVD_BYTE0 = 3'd2;
    localparam logic [ERR_W-1:0] ERR_RSVD_BYTE1 = 3'd3;
    localparam logic [ERR_W-1:0] ERR_RSVD_BYTE2 = 3'd4;
    localparam logic [ERR_W-1:0] ERR_OSID_MSB   = 3'd5;

    // Header check masks.
    localparam logic [DATA_W-1:0] ID_CONF_MASK   = 8'h80;
    localparam logic [DATA_W-1:0] ID_RSVD_MASK   = 8'h7A;
    localparam logic [DATA_W-1:0] FLAG_RSVD_MASK = 8'hF0;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_INTPTR = 4'b0010,
        PH_DIR    = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] record_kind;
        logic [ERR_W-1:0]  error_code;
        logic [5:0]        card_flags;
        logic [15:0]       product_id;
        logic [15:0]       maker_id;
        logic [7:0]        country_code;
        logic [31:0]       irq_pointer;
        logic [31:0]       fiq_pointer;
        logic [2:0]        os_type;
        logic [3:0]        os_subtype;
        logic [23:0]       chunk_size;
        logic [31:0]       chunk_address;
    } result_t;

endpackage

`default_nettype wire

// ----- src/ecp_in_stage.sv -----
// Input register that holds one accepted item until the parser consumes it.
`default_nettype none

module ecp_in_stage (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [ecp_pkg::DATA_W-1:0] s_tdata,
    input  wire logic                       s_tlast,
    input  wire logic                       advance,
    output logic                            item_valid,
    output logic [ecp_pkg::DATA_W-1:0]      item_byte,
    output logic                            item_last
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [ecp_pkg::DATA_W-1:0] byte_reg;
    logic                      last_reg;
    logic                      accept;

    assign s_tready = !valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;
    assign item_last  = last_reg;

endmodule

`default_nettype wire

// ----- src/ecp_parse.sv -----
// Parser state and the per-byte decode that produces at most one record.
`default_nettype none

module ecp_parse (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       consume,
    input  wire logic [ecp_pkg::DATA_W-1:0] data_byte,
    input  wire logic                       last_byte,
    output ecp_pkg::result_t                res
);

    ecp_pkg::phase_t            phase_reg, phase_next;
    logic [ecp_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]                 id_reg, id_next;
    logic [7:0]                 flag_reg, flag_next;
    logic [15:0]                product_reg, product_next;
    logic [15:0]                maker_reg, maker_next;
    logic [7:0]                 country_reg, country_next;
    logic [31:0]                irq_reg, irq_next;
    logic [31:0]                fiq_reg, fiq_next;
    logic [7:0]                 osid_reg, osid_next;
    logic [23:0]                size_reg, size_next;
    logic [31:0]                addr_reg, addr_next;

    always_comb
    begin
        logic emit_hdr;
        logic pos_end;

        emit_hdr     = 1'b0;
        pos_end      = (pos_reg == 3'd7);
        res          = '0;
        phase_next   = phase_reg;
        pos_next     = pos_reg + 3'd1;
        id_next      = id_reg;
        flag_next    = flag_reg;
        product_next = product_reg;
        maker_next   = maker_reg;
        country_next = country_reg;
        irq_next     = irq_reg;
        fiq_next     = fiq_reg;
        osid_next    = osid_reg;
        size_next    = size_reg;
        addr_next    = addr_reg;

        case (phase_reg)
            ecp_pkg::PH_HEADER:
            begin
                case (pos_reg)
                    3'd0:
                    begin
                        id_next = data_byte;
                        if ((data_byte & ecp_pkg::ID_CONF_MASK) != '0)
                        begin
                            res.valid      = 1'b1;
                            res.error_code = ecp_pkg::ERR_NOT_CONF;
                        end
                        else if ((data_byte & ecp_pkg::ID_RSVD_MASK) != '0)
                        begin
                            res.valid      = 1'b1;
                            res.error_code = ecp_pkg::ERR_RSVD_BYTE0;
                        end
                    end
                    3'd1:
                    begin
                        flag_next = data_byte;
                        if ((data_byte & ecp_pkg::FLAG_RSVD_MASK) != '0)
                        begin
                            res.valid      = 1'b1;
                            res.error_code = ecp_pkg::ERR_RSVD_BYTE1;
                        end
                    end
                    3'd2:
                    begin
                        if (data_byte != '0)
                        begin
                            res.valid      = 1'b1;
                            res.error_code = ecp_pkg::ERR_RSVD_BYTE2;
                        end
                    end
                    3'd3: product_next[7:0]  = data_byte;
                    3'd4: product_next[15:8] = data_byte;
                    3'd5: maker_next[7:0]    = data_byte;
                    3'd6: maker_next[15:8]   = data_byte;
                    default:
                    begin
                        country_next = data_byte;
                        if (flag_reg[1])
                        begin
                            phase_next = ecp_pkg::PH_INTPTR;
                            pos_next   = '0;
                        end
                        else
                        begin
                            emit_hdr = 1'b1;
                        end
                    end
                endcase
                if (res.valid)
                begin
                    res.record_kind = ecp_pkg::KIND_ERROR;
                    phase_next      = ecp_pkg::PH_DONE;
                end
            end
            ecp_pkg::PH_INTPTR:
            begin
                // Each pointer arrives mask byte first, then its address low to high.
                case (pos_reg)
                    3'd0: irq_next[31:24] = data_byte;
                    3'd1: irq_next[7:0]   = data_byte;
                    3'd2: irq_next[15:8]  = data_byte;
                    3'd3: irq_next[23:16] = data_byte;
                    3'd4: fiq_next[31:24] = data_byte;
                    3'd5: fiq_next[7:0]   = data_byte;
                    3'd6: fiq_next[15:8]  = data_byte;
                    default: fiq_next[23:16] = data_byte;
                endcase
                emit_hdr = pos_end;
            end
            ecp_pkg::PH_DIR:
            begin
                case (pos_reg)
                    3'd0: osid_next         = data_byte;
                    3'd1: size_next[7:0]    = data_byte;
                    3'd2: size_next[15:8]   = data_byte;
                    3'd3: size_next[23:16]  = data_byte;
                    3'd4: addr_next[7:0]    = data_byte;
                    3'd5: addr_next[15:8]   = data_byte;
                    3'd6: addr_next[23:16]  = data_byte;
                    default: addr_next[31:24] = data_byte;
                endcase
                if (pos_end)
                begin
                    res.valid = 1'b1;
                    pos_next  = '0;
                    if (osid_next == '0 && size_next == '0)
                    begin
                        res.record_kind = ecp_pkg::KIND_END;
                        phase_next      = ecp_pkg::PH_DONE;
                    end
                    else if (!osid_next[7])
                    begin
                        res.record_kind = ecp_pkg::KIND_ERROR;
                        res.error_code  = ecp_pkg::ERR_OSID_MSB;
                        phase_next      = ecp_pkg::PH_DONE;
                    end
                    else
                    begin
                        res.record_kind   = ecp_pkg::KIND_CHUNK;
                        res.os_type       = osid_next[6:4];
                        res.os_subtype    = osid_next[3:0];
                        res.chunk_size    = size_next;
                        res.chunk_address = addr_next;
                    end
                end
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase

        if (emit_hdr)
        begin
            res.valid        = 1'b1;
            res.record_kind  = ecp_pkg::KIND_HEADER;
            res.card_flags   = {flag_reg[3:2], flag_reg[1], flag_reg[0], id_reg[2], id_reg[0]};
            res.product_id   = product_next;
            res.maker_id     = maker_next;
            res.country_code = country_next;
            res.irq_pointer  = irq_next;
            res.fiq_pointer  = fiq_next;
            phase_next       = flag_reg[0] ? ecp_pkg::PH_DIR : ecp_pkg::PH_DONE;
            pos_next         = '0;
        end

        // The final byte of an image is decoded as usual, then everything rearms.
        if (last_byte)
        begin
            phase_next   = ecp_pkg::PH_HEADER;
            pos_next     = '0;
            id_next      = '0;
            flag_next    = '0;
            product_next = '0;
            maker_next   = '0;
            country_next = '0;
            irq_next     = '0;
            fiq_next     = '0;
            osid_next    = '0;
            size_next    = '0;
            addr_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= ecp_pkg::PH_HEADER;
            pos_reg     <= '0;
            id_reg      <= '0;
            flag_reg    <= '0;
            product_reg <= '0;
            maker_reg   <= '0;
            country_reg <= '0;
            irq_reg     <= '0;
            fiq_reg     <= '0;
            osid_reg    <= '0;
            size_reg    <= '0;
            addr_reg    <= '0;
        end
        else if (consume)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            id_reg      <= id_next;
            flag_reg    <= flag_next;
            product_reg <= product_next;
            maker_reg   <= maker_next;
            country_reg <= country_next;
            irq_reg     <= irq_next;
            fiq_reg     <= fiq_next;
            osid_reg    <= osid_next;
            size_reg    <= size_next;
            addr_reg    <= addr_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/ecp_out_stage.sv -----
// Result register that holds one record until the downstream side takes it.
`default_nettype none

module ecp_out_stage (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           load,
    input  wire ecp_pkg::result_t               res,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [ecp_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [ecp_pkg::KIND_W-1:0]          m_tuser
);

    logic             valid_reg;
    logic             valid_next;
    ecp_pkg::result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.record_kind;
    assign m_tdata  = {res_reg.chunk_address, res_reg.chunk_size, res_reg.os_subtype,
                       res_reg.os_type, res_reg.fiq_pointer, res_reg.irq_pointer,
                       res_reg.country_code, res_reg.maker_id, res_reg.product_id,
                       res_reg.card_flags, res_reg.error_code};

endmodule

`default_nettype wire

// ----- src/expansion_card_id_chunk_parser_top.sv -----
// A byte waits in the input register; its record, if any, is loaded into the result register.
// Throughput: one byte per cycle while the output side keeps taking records; the input register
// refills as it hands a byte on, and the result register loads only bytes that yield a record.
// The per-byte decode between the two registers is a field capture and a few compares.
// Reset (rst_n low, asynchronous) empties both registers and returns the parser to the
// identity header with all captured fields cleared.
`default_nettype none

module expansion_card_id_chunk_parser_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ecp_pkg::DATA_W-1:0]     s_tdata,   // [7:0] data_byte
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [2:0] error_code, [8:3] card_flags, [24:9] product_id, [40:25] maker_id,
    // [48:41] country_code, [80:49] irq_pointer, [112:81] fiq_pointer,
    // [115:113] os_type, [119:116] os_subtype, [143:120] chunk_size,
    // [175:144] chunk_address
    output logic [ecp_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [ecp_pkg::KIND_W-1:0]          m_tuser    // [1:0] record_kind
);

    logic                       item_valid;
    logic [ecp_pkg::DATA_W-1:0] item_byte;
    logic                       item_last;
    logic                       advance;
    ecp_pkg::result_t           res;

    // A byte that yields no record never waits on the output side.
    assign advance = item_valid && (!res.valid || !m_tvalid || m_tready);

    ecp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_last  (item_last)
    );

    ecp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .consume   (advance),
        .data_byte (item_byte),
        .last_byte (item_last),
        .res       (res)
    );

    ecp_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && res.valid),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ----- src/ecp_checker.sv -----
// Port-level checks for the parser, bound to the top level.
`default_nettype none

module ecp_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [ecp_pkg::DATA_W-1:0]     s_tdata,
    input wire logic                           s_tlast,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [ecp_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic [ecp_pkg::KIND_W-1:0]     m_tuser
);

    // A record held back by the sink must not change.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output record changed while stalled");

    // Error records carry a real error code, all other records carry none.
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == ecp_pkg::KIND_ERROR) == (m_tdata[2:0] != ecp_pkg::ERR_NONE)))
        else $error("error code does not match record kind");

    // A header record never carries chunk fields.
    a_hdr_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ecp_pkg::KIND_HEADER |-> m_tdata[175:113] == '0)
        else $error("header record carries chunk fields");

    // Interrupt pointers are only captured when the header announces them.
    a_ptr_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ecp_pkg::KIND_HEADER && m_tdata[112:49] != '0
        |-> m_tdata[6])
        else $error("pointer block present without its flag");

endmodule

bind expansion_card_id_chunk_parser_top ecp_checker u_ecp_checker (.*);

`default_nettype wire
